FILE: rtl/asmc_pkg.sv
package asmc_pkg;

  localparam int DATA_W    = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  // digit width of the shared multiplier (multiplicand x digit per cycle)
  localparam int MUL_DIGIT = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SURFACE_GAIN  = 3'd0,
    CFG_SWITCH_GAIN   = 3'd1,
    CFG_PLANT_GAIN    = 3'd2,
    CFG_OBSERVER_BW   = 3'd3,
    CFG_DRIVE_LIMIT   = 3'd4,
    CFG_SAMPLE_PERIOD = 3'd5
  } cfg_idx_e;

  typedef logic signed [DATA_W-1:0] data_t;

endpackage

FILE: rtl/asmc_req_if.sv
interface asmc_req_if import asmc_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t feedback_angle;
  data_t target_angle;
  data_t angular_rate;

  modport source (output valid, output feedback_angle, output target_angle,
                  output angular_rate, input ready);
  modport sink   (input valid, input feedback_angle, input target_angle,
                  input angular_rate, output ready);
endinterface

FILE: rtl/asmc_rsp_if.sv
interface asmc_rsp_if import asmc_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t drive;

  modport source (output valid, output drive, input ready);
  modport sink   (input valid, input drive, output ready);
endinterface

FILE: rtl/asmc_mul.sv
module asmc_mul import asmc_pkg::*; #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [WORD_WIDTH-1:0] a_i,
  input  logic signed [WORD_WIDTH-1:0] b_i,
  output logic                         done_o,
  output logic signed [WORD_WIDTH-1:0] p_o
);

  localparam int W   = WORD_WIDTH;
  localparam int NCH = (W + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int BW  = NCH * MUL_DIGIT;
  localparam int CW  = $clog2(NCH + 1);
  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  logic                  busy_q, fin_q, done_q, neg_q;
  logic [CW-1:0]         cnt_q;
  logic [W-1:0]          am_q;
  logic [BW-1:0]         bm_q;
  logic [2*W-1:0]        acc_q;
  logic signed [W-1:0]   p_q;

  logic [W-1:0]          a_mag, b_mag;
  logic [W+MUL_DIGIT-1:0] pp;
  logic signed [2*W:0]   fin_v, fin_sh;
  logic [W+1:0]          fin_hi;
  logic signed [W-1:0]   fin_p;

  assign a_mag = a_i[W-1] ? $unsigned(-a_i) : $unsigned(a_i);
  assign b_mag = b_i[W-1] ? $unsigned(-b_i) : $unsigned(b_i);

  // top digit of the multiplier first, accumulator shifts up one digit a step
  assign pp = (W+MUL_DIGIT)'(am_q) * (W+MUL_DIGIT)'(bm_q[BW-1 -: MUL_DIGIT]);

  // exact product, floor shift, saturate to the word
  assign fin_v  = neg_q ? -$signed({1'b0, acc_q}) : $signed({1'b0, acc_q});
  assign fin_sh = fin_v >>> FRAC_BITS;
  assign fin_hi = fin_sh[2*W:W-1];
  assign fin_p  = (&fin_hi || ~|fin_hi) ? fin_sh[W-1:0] : (fin_sh[2*W] ? WMIN : WMAX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NCH);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      neg_q <= a_i[W-1] ^ b_i[W-1];
      am_q  <= a_mag;
      bm_q  <= BW'(b_mag);
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= (acc_q << MUL_DIGIT) + (2*W)'(pp);
      bm_q  <= bm_q << MUL_DIGIT;
    end
    if (fin_q) begin
      p_q <= fin_p;
    end
  end

  assign done_o = done_q;
  assign p_o    = p_q;

endmodule

FILE: rtl/asmc_div.sv
module asmc_div import asmc_pkg::*; #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [WORD_WIDTH-1:0] num_i,
  input  logic signed [WORD_WIDTH-1:0] den_i,
  output logic                         done_o,
  output logic signed [WORD_WIDTH-1:0] q_o
);

  localparam int W  = WORD_WIDTH;
  localparam int NB = W + FRAC_BITS;
  localparam int CW = $clog2(NB + 1);
  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0]        HALF = {1'b1, {(W-1){1'b0}}};

  logic                busy_q, fin_q, done_q, neg_q, ovf_q;
  logic [CW-1:0]       cnt_q;
  logic [NB-1:0]       dv_q;
  logic [W-2:0]        rem_q, ud_q;
  logic [W-1:0]        qt_q;
  logic signed [W-1:0] q_q;

  logic [W-1:0]        n_mag, r2, diff, tot;
  logic                ge, special, big;
  logic signed [W-1:0] special_q, fin_q_val;

  assign n_mag   = num_i[W-1] ? $unsigned(-num_i) : $unsigned(num_i);
  assign special = (num_i == '0) || (den_i == '0) || den_i[W-1];
  always_comb begin
    if (num_i == '0) begin
      special_q = '0;
    end else begin
      special_q = num_i[W-1] ? WMIN : WMAX;
    end
  end

  // restoring step: one quotient bit per cycle
  assign r2   = {rem_q, dv_q[NB-1]};
  assign diff = r2 - {1'b0, ud_q};
  assign ge   = r2 >= {1'b0, ud_q};

  // clip the magnitude at one past the word maximum, then apply the sign
  assign big = ovf_q || (qt_q > HALF);
  assign tot = big ? HALF : qt_q;
  always_comb begin
    if (neg_q) begin
      fin_q_val = $signed(-tot);
    end else if (tot == HALF) begin
      fin_q_val = WMAX;
    end else begin
      fin_q_val = $signed(tot);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (start_i && !busy_q) begin
        if (special) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= CW'(NB);
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      neg_q <= num_i[W-1];
      dv_q  <= {n_mag, {FRAC_BITS{1'b0}}};
      rem_q <= '0;
      ud_q  <= den_i[W-2:0];
      qt_q  <= '0;
      ovf_q <= 1'b0;
      if (special) begin
        q_q <= special_q;
      end
    end else if (busy_q) begin
      rem_q <= ge ? diff[W-2:0] : r2[W-2:0];
      qt_q  <= {qt_q[W-2:0], ge};
      ovf_q <= ovf_q | qt_q[W-1];
      dv_q  <= dv_q << 1;
    end
    if (fin_q) begin
      q_q <= fin_q_val;
    end
  end

  assign done_o = done_q;
  assign q_o    = q_q;

endmodule

FILE: rtl/adrc_sliding_mode_controller.sv
// Sliding-mode controller with a two-state extended observer, one sample per request.
// Each request runs through a short sequencer that reuses one saturating adder, one
// multiplier that takes a 16-bit digit of the multiplier per cycle, and a restoring
// divider that produces one quotient bit per cycle. Each sample
// runs nine multiplies and one divide through these units, in a fixed order.
// A zero numerator or zero plant gain skips the divide. The input side is ready only
// between samples; the result waits in an output register, so the next request may be
// taken while it is still pending. Write configuration only while no sample is in work.
module adrc_sliding_mode_controller import asmc_pkg::*; #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  asmc_req_if.sink             req_i,
  asmc_rsp_if.source           rsp_o
);

  localparam int W = WORD_WIDTH;
  localparam logic signed [63:0] WMAX64 = (64'sd1 <<< (W-1)) - 64'sd1;
  localparam logic signed [63:0] WMIN64 = -WMAX64 - 64'sd1;
  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [30:0] B0_RST = 31'(64'd1 << FRAC_BITS);
  localparam logic [30:0] TP_RST = 31'(((64'd1 << FRAC_BITS) * 2 + 64'd500) / 64'd1000);

  typedef enum logic [22:0] {
    ST_IDLE = 23'h000001,
    ST_DIF  = 23'h000002,
    ST_DBL  = 23'h000004,
    ST_ERR  = 23'h000008,
    ST_WW   = 23'h000010,
    ST_G2   = 23'h000020,
    ST_GD   = 23'h000040,
    ST_Z2   = 23'h000080,
    ST_BU   = 23'h000100,
    ST_IN1  = 23'h000200,
    ST_WD   = 23'h000400,
    ST_IN2  = 23'h000800,
    ST_TI   = 23'h001000,
    ST_Z1   = 23'h002000,
    ST_WE   = 23'h004000,
    ST_SRF  = 23'h008000,
    ST_WZ   = 23'h010000,
    ST_NEG  = 23'h020000,
    ST_KS   = 23'h040000,
    ST_TERM = 23'h080000,
    ST_NUM  = 23'h100000,
    ST_DIV  = 23'h200000,
    ST_OUT  = 23'h400000
  } state_e;

  function automatic logic signed [W-1:0] sat_word(input logic signed [63:0] v);
    logic signed [W-1:0] r;
    if (v > WMAX64) begin
      r = WMAX;
    end else if (v < WMIN64) begin
      r = WMIN;
    end else begin
      r = W'(v);
    end
    return r;
  endfunction

  // configuration
  logic signed [CFG_W-1:0] wc_q, k_q, wo_q;
  logic [30:0]             b0_q, lim_q, tp_q;
  logic signed [W-1:0]     wc_w, k_w, wo_w, b0_w, lim_w, tp_w;

  // sequencer and state
  state_e              state_q, state_d;
  logic                issued_q, issued_d;
  logic signed [W-1:0] z1_q, z2_q, ul_q;
  logic                out_valid_q;
  data_t               drive_q;

  // per-sample working registers
  logic signed [W-1:0] fdb_q, set_q, gyro_q, d_q, w2_q, e_q, in_q, s_q, t_q;

  // shared units
  logic                is_mul, mul_start, mul_done, div_start, div_done;
  logic signed [W-1:0] mul_a, mul_b, mul_p, div_q;
  logic signed [W-1:0] add_a, add_b, add_r;
  logic                add_sub;
  logic signed [W:0]   add_x;
  logic signed [W-1:0] neg_lim, u_clamp;
  logic                accept, out_load;

  assign wc_w  = sat_word(64'(wc_q));
  assign k_w   = sat_word(64'(k_q));
  assign wo_w  = sat_word(64'(wo_q));
  assign b0_w  = sat_word(64'(b0_q));
  assign lim_w = sat_word(64'(lim_q));
  assign tp_w  = sat_word(64'(tp_q));

  assign accept      = req_i.valid && (state_q == ST_IDLE);
  assign req_i.ready = (state_q == ST_IDLE);
  assign out_load    = (state_q == ST_OUT) && (!out_valid_q || rsp_o.ready);
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.drive = drive_q;

  // operand routing for the multiplier
  always_comb begin
    is_mul = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (state_q)
      ST_WW: begin
        mul_a = wo_w;
        mul_b = wo_w;
      end
      ST_G2: begin
        mul_a = tp_w;
        mul_b = mul_p;
      end
      ST_GD: begin
        mul_a = mul_p;
        mul_b = d_q;
      end
      ST_BU: begin
        mul_a = b0_w;
        mul_b = ul_q;
      end
      ST_WD: begin
        mul_a = w2_q;
        mul_b = d_q;
      end
      ST_TI: begin
        mul_a = tp_w;
        mul_b = in_q;
      end
      ST_WE: begin
        mul_a = wc_w;
        mul_b = e_q;
      end
      ST_WZ: begin
        mul_a = wc_w;
        mul_b = z1_q;
      end
      ST_KS: begin
        mul_a = k_w;
        mul_b = s_q;
      end
      default: begin
        is_mul = 1'b0;
      end
    endcase
  end

  assign mul_start = is_mul && !issued_q;
  assign div_start = (state_q == ST_DIV) && !issued_q;

  // operand routing for the saturating adder
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (state_q)
      ST_DIF: begin
        add_a   = gyro_q;
        add_b   = z1_q;
        add_sub = 1'b1;
      end
      ST_DBL: begin
        add_a = wo_w;
        add_b = wo_w;
      end
      ST_ERR: begin
        add_a   = fdb_q;
        add_b   = set_q;
        add_sub = 1'b1;
      end
      ST_Z2: begin
        add_a = z2_q;
        add_b = mul_p;
      end
      ST_IN1: begin
        add_a = mul_p;
        add_b = z2_q;
      end
      ST_IN2: begin
        add_a = in_q;
        add_b = mul_p;
      end
      ST_Z1: begin
        add_a = z1_q;
        add_b = mul_p;
      end
      ST_SRF: begin
        add_a = mul_p;
        add_b = z1_q;
      end
      ST_NEG: begin
        add_b   = mul_p;
        add_sub = 1'b1;
      end
      ST_TERM: begin
        add_a   = t_q;
        add_b   = mul_p;
        add_sub = 1'b1;
      end
      ST_NUM: begin
        add_a   = t_q;
        add_b   = z2_q;
        add_sub = 1'b1;
      end
      default: begin
        add_sub = 1'b0;
      end
    endcase
  end

  assign add_x = add_sub ? ((W+1)'(add_a) - (W+1)'(add_b))
                         : ((W+1)'(add_a) + (W+1)'(add_b));
  assign add_r = (add_x[W] == add_x[W-1]) ? add_x[W-1:0] : (add_x[W] ? WMIN : WMAX);

  assign neg_lim = -lim_w;
  assign u_clamp = (div_q > lim_w) ? lim_w : ((div_q < neg_lim) ? neg_lim : div_q);

  always_comb begin
    state_d  = state_q;
    issued_d = issued_q;
    if (mul_start || div_start) begin
      issued_d = 1'b1;
    end
    if (mul_done || div_done) begin
      issued_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_DIF;
      ST_DIF:  state_d = ST_DBL;
      ST_DBL:  state_d = ST_ERR;
      ST_ERR:  state_d = ST_WW;
      ST_WW:   if (mul_done) state_d = ST_G2;
      ST_G2:   if (mul_done) state_d = ST_GD;
      ST_GD:   if (mul_done) state_d = ST_Z2;
      ST_Z2:   state_d = ST_BU;
      ST_BU:   if (mul_done) state_d = ST_IN1;
      ST_IN1:  state_d = ST_WD;
      ST_WD:   if (mul_done) state_d = ST_IN2;
      ST_IN2:  state_d = ST_TI;
      ST_TI:   if (mul_done) state_d = ST_Z1;
      ST_Z1:   state_d = ST_WE;
      ST_WE:   if (mul_done) state_d = ST_SRF;
      ST_SRF:  state_d = ST_WZ;
      ST_WZ:   if (mul_done) state_d = ST_NEG;
      ST_NEG:  state_d = ST_KS;
      ST_KS:   if (mul_done) state_d = ST_TERM;
      ST_TERM: state_d = ST_NUM;
      ST_NUM:  state_d = ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_OUT;
      ST_OUT:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
      z1_q        <= '0;
      z2_q        <= '0;
      ul_q        <= '0;
      wc_q        <= '0;
      k_q         <= '0;
      b0_q        <= B0_RST;
      wo_q        <= '0;
      lim_q       <= '0;
      tp_q        <= TP_RST;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
        ul_q        <= u_clamp;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_Z2) begin
        z2_q <= add_r;
      end
      if (state_q == ST_Z1) begin
        z1_q <= add_r;
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_SURFACE_GAIN:  wc_q  <= cfg_data_i;
          CFG_SWITCH_GAIN:   k_q   <= cfg_data_i;
          CFG_PLANT_GAIN:    b0_q  <= cfg_data_i[30:0];
          CFG_OBSERVER_BW:   wo_q  <= cfg_data_i;
          CFG_DRIVE_LIMIT:   lim_q <= cfg_data_i[30:0];
          CFG_SAMPLE_PERIOD: tp_q  <= cfg_data_i[30:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fdb_q  <= sat_word(64'(req_i.feedback_angle));
      set_q  <= sat_word(64'(req_i.target_angle));
      gyro_q <= sat_word(64'(req_i.angular_rate));
    end
    case (state_q)
      ST_DIF:  d_q  <= add_r;
      ST_DBL:  w2_q <= add_r;
      ST_ERR:  e_q  <= add_r;
      ST_IN1:  in_q <= add_r;
      ST_IN2:  in_q <= add_r;
      ST_SRF:  s_q  <= add_r;
      ST_NEG:  t_q  <= add_r;
      ST_TERM: t_q  <= add_r;
      ST_NUM:  t_q  <= add_r;
      default: ;
    endcase
    if (out_load) begin
      drive_q <= DATA_W'(u_clamp);
    end
  end

  asmc_mul #(
    .WORD_WIDTH (WORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  asmc_div #(
    .WORD_WIDTH (WORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (t_q),
    .den_i   (b0_w),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  a_clamp_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |-> (u_clamp <= lim_w) && (u_clamp >= neg_lim))
    else $error("drive outside the clamp");

  a_mul_done_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> issued_q && is_mul)
    else $error("multiplier finished without a pending operation");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> issued_q && (state_q == ST_DIV))
    else $error("divider finished outside the divide step");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> (state_q == ST_DIF) && !issued_q)
    else $error("accepted request did not start the sequence");

endmodule
